// File: rtl/sliding_mode_speed_controller_top_macros.svh
// ---------------------------------------------------------------------------
// Sliding mode speed controller assertion macros
// Clocked, reset-qualified property shorthands used by the top level.
// ---------------------------------------------------------------------------
`ifndef SLIDING_MODE_SPEED_CONTROLLER_TOP_MACROS_SVH
`define SLIDING_MODE_SPEED_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define SMSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/smsc_pkg.sv
// ---------------------------------------------------------------------------
// Sliding mode speed controller package
// Widths, register codes, controller states and control interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package smsc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int DIVR_W    = 15;
    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int DERR_W    = SAMPLE_W + 2;
    localparam int DD_W      = SAMPLE_W + 3;
    localparam int SURF_W    = 34;
    localparam int SUM_W     = COEF_W + SURF_W;
    localparam int DRIVE_W   = 32;
    localparam int DIV_STEPS = SUM_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int S_DATA_W  = 2 * SAMPLE_W;
    localparam int M_DATA_W  = ((DRIVE_W + ERR_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SURFACE_SLOPE = 2'd0,
        CFG_REACH_GAIN    = 2'd1,
        CFG_SWITCH_GAIN   = 2'd2,
        CFG_PLANT_DIVISOR = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_C_ERR  = 2'd0,
        MUL_C_DERR = 2'd1,
        MUL_K_S    = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_MUL_CE   = 4'd1,
        ST_SURF     = 4'd2,
        ST_ACC_CD   = 4'd3,
        ST_ACC_KS   = 4'd4,
        ST_ACC_SW   = 4'd5,
        ST_DIV_INIT = 4'd6,
        ST_DIV      = 4'd7,
        ST_OUT      = 4'd8
    } smsc_state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     surf_en;
        logic     acc_prod;
        logic     acc_sw;
        logic     div_start;
        logic     div_step;
        logic     out_load;
    } smsc_cmd_t;

    typedef struct packed {
        logic div_done;
    } smsc_status_t;

endpackage

`default_nettype wire

// File: rtl/sliding_mode_speed_controller_top.sv
// ---------------------------------------------------------------------------
// Sliding mode speed controller
// Constant-plus-proportional reaching law drive from set point and feedback.
// ---------------------------------------------------------------------------
//  channel  | ports                         | contents
//  s_       | s_tvalid s_tready s_tdata[31:0] | set_point, feedback
//  m_       | m_tvalid m_tready m_tdata[55:0] | drive, tracking_error
//  cfg      | cfg_wr_en cfg_index cfg_wdata | surface_slope .. plant_divisor
//
//  One transaction is stepped around the shared 16x34 multiplier, then
//  through the 2-bit-per-cycle divider on the 50-bit control sum.
//  A new transaction is taken while the previous result waits on m_tready;
//  it then stalls at the output until the result register frees up.
//  aresetn is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sliding_mode_speed_controller_top_macros.svh"

module sliding_mode_speed_controller_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [smsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [smsc_pkg::COEF_W-1:0]       cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [smsc_pkg::S_DATA_W-1:0]     s_tdata,  // set_point, feedback
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [smsc_pkg::M_DATA_W-1:0]          m_tdata   // drive, tracking_error, pad
);

    smsc_pkg::smsc_cmd_t    cmd;
    smsc_pkg::smsc_status_t status;

    smsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smsc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_tdata)
    );

    `SMSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `SMSC_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, m_tvalid, "result load lost")
    `SMSC_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "pending result overwritten")
    `SMSC_ASSERT_IMPL(a_idle_no_divide, s_tready, !cmd.div_step && !cmd.out_load, "work while idle")

endmodule

`default_nettype wire

// File: rtl/smsc_datapath.sv
// ---------------------------------------------------------------------------
// Sliding mode speed controller datapath
// Sample history, shared multiplier, accumulator, radix-4 divider, output regs.
// ---------------------------------------------------------------------------
`default_nettype none

module smsc_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [smsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [smsc_pkg::COEF_W-1:0]         cfg_wdata,
    input  wire logic [smsc_pkg::S_DATA_W-1:0]       s_data,
    input  wire smsc_pkg::smsc_cmd_t                 cmd,
    output smsc_pkg::smsc_status_t                   status,
    output logic [smsc_pkg::M_DATA_W-1:0]            m_data
);

    localparam int SW  = smsc_pkg::SUM_W;
    localparam int SAW = smsc_pkg::SAMPLE_W;
    localparam int DW  = smsc_pkg::DRIVE_W;
    localparam int BW  = smsc_pkg::DIVR_W;
    localparam logic [SW-1:0] POS_LIMIT = {{(SW-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}};
    localparam logic [SW-1:0] NEG_LIMIT = {{(SW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    logic signed [smsc_pkg::COEF_W-1:0] c_reg, k_reg, epc_reg;
    logic        [BW-1:0]               b_reg;

    logic signed [SAW-1:0] last_fb_reg, last_sp_reg, prior_sp_reg;

    logic signed [smsc_pkg::ERR_W-1:0]  err_reg;
    logic signed [smsc_pkg::DERR_W-1:0] derr_reg;
    logic signed [smsc_pkg::SURF_W-1:0] s_reg;
    logic signed [SW-1:0]               prod_reg;
    logic signed [SW-1:0]               acc_reg;
    logic        [BW-1:0]               rem_reg;
    logic        [SW-1:0]               quo_reg;
    logic                               neg_reg;
    logic        [smsc_pkg::DCNT_W-1:0] cnt_reg;
    logic        [DW-1:0]               drive_reg;
    logic        [smsc_pkg::ERR_W-1:0]  terr_reg;

    logic signed [SAW-1:0]              sp, fb;
    logic signed [smsc_pkg::ERR_W-1:0]  d_fb, d_sp, err;
    logic signed [smsc_pkg::DERR_W-1:0] derr;
    logic signed [smsc_pkg::DD_W-1:0]   dd_sp;
    logic signed [SW-1:0]               acc_init;

    logic signed [smsc_pkg::COEF_W-1:0] mul_a;
    logic signed [smsc_pkg::SURF_W-1:0] mul_b;
    logic signed [SW-1:0]               mul_res;
    logic signed [SW-1:0]               sw_term;

    logic [BW-1:0] b_eff;
    logic [BW:0]   rem1, rem2;
    logic          ge1, ge2;
    logic [BW-1:0] r1, r2;
    logic [SW-1:0] q1, q2;
    logic [SW-1:0] quo_neg;
    logic [DW-1:0] drive_sat;

    // input differences
    always_comb begin
        sp    = $signed(s_data[SAW-1:0]);
        fb    = $signed(s_data[2*SAW-1:SAW]);
        d_fb  = smsc_pkg::ERR_W'(fb) - smsc_pkg::ERR_W'(last_fb_reg);
        d_sp  = smsc_pkg::ERR_W'(sp) - smsc_pkg::ERR_W'(last_sp_reg);
        err   = smsc_pkg::ERR_W'(sp) - smsc_pkg::ERR_W'(fb);
        derr  = smsc_pkg::DERR_W'(d_sp) - smsc_pkg::DERR_W'(d_fb);
        dd_sp = smsc_pkg::DD_W'(sp) - (smsc_pkg::DD_W'(last_sp_reg) <<< 1)
              + smsc_pkg::DD_W'(prior_sp_reg);
        acc_init = SW'(dd_sp) + SW'(fb) + SW'(d_fb);
    end

    // shared multiplier
    always_comb begin
        case (cmd.mul_sel)
            smsc_pkg::MUL_C_ERR: begin
                mul_a = c_reg;
                mul_b = smsc_pkg::SURF_W'(err_reg);
            end
            smsc_pkg::MUL_C_DERR: begin
                mul_a = c_reg;
                mul_b = smsc_pkg::SURF_W'(derr_reg);
            end
            smsc_pkg::MUL_K_S: begin
                mul_a = k_reg;
                mul_b = s_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    always_comb begin
        if (s_reg > 0) begin
            sw_term = SW'(epc_reg);
        end else if (s_reg < 0) begin
            sw_term = -SW'(epc_reg);
        end else begin
            sw_term = '0;
        end
    end

    // two restoring division steps per cycle
    always_comb begin
        b_eff = (b_reg == '0) ? BW'(1) : b_reg;
        rem1  = {rem_reg, quo_reg[SW-1]};
        ge1   = rem1 >= {1'b0, b_eff};
        r1    = ge1 ? BW'(rem1 - {1'b0, b_eff}) : rem1[BW-1:0];
        q1    = {quo_reg[SW-2:0], ge1};
        rem2  = {r1, q1[SW-1]};
        ge2   = rem2 >= {1'b0, b_eff};
        r2    = ge2 ? BW'(rem2 - {1'b0, b_eff}) : rem2[BW-1:0];
        q2    = {q1[SW-2:0], ge2};
    end

    always_comb begin
        quo_neg = -quo_reg;
        if (neg_reg) begin
            drive_sat = (quo_reg > NEG_LIMIT) ? NEG_LIMIT[DW-1:0] : quo_neg[DW-1:0];
        end else begin
            drive_sat = (quo_reg > POS_LIMIT) ? POS_LIMIT[DW-1:0] : quo_reg[DW-1:0];
        end
    end

    // configuration registers, sample history and divide step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg        <= '0;
            k_reg        <= '0;
            epc_reg      <= '0;
            b_reg        <= BW'(1);
            last_fb_reg  <= '0;
            last_sp_reg  <= '0;
            prior_sp_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    smsc_pkg::CFG_SURFACE_SLOPE: c_reg   <= $signed(cfg_wdata);
                    smsc_pkg::CFG_REACH_GAIN:    k_reg   <= $signed(cfg_wdata);
                    smsc_pkg::CFG_SWITCH_GAIN:   epc_reg <= $signed(cfg_wdata);
                    smsc_pkg::CFG_PLANT_DIVISOR: b_reg   <= cfg_wdata[BW-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                last_fb_reg  <= fb;
                last_sp_reg  <= sp;
                prior_sp_reg <= last_sp_reg;
            end
            if (cmd.div_start) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + smsc_pkg::DCNT_W'(1);
            end
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg  <= err;
            derr_reg <= derr;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_res;
        end
        if (cmd.surf_en) begin
            s_reg <= prod_reg[smsc_pkg::SURF_W-1:0] + smsc_pkg::SURF_W'(derr_reg);
        end
        if (cmd.load) begin
            acc_reg <= acc_init;
        end else if (cmd.acc_prod) begin
            acc_reg <= acc_reg + prod_reg;
        end else if (cmd.acc_sw) begin
            acc_reg <= acc_reg + sw_term;
        end
        if (cmd.div_start) begin
            neg_reg <= acc_reg[SW-1];
            quo_reg <= acc_reg[SW-1] ? -acc_reg : acc_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= q2;
            rem_reg <= r2;
        end
        if (cmd.out_load) begin
            drive_reg <= drive_sat;
            terr_reg  <= err_reg;
        end
    end

    assign status.div_done = (cnt_reg == smsc_pkg::DCNT_W'(smsc_pkg::DIV_STEPS - 1));
    assign m_data = {{(smsc_pkg::M_DATA_W - DW - smsc_pkg::ERR_W){1'b0}}, terr_reg, drive_reg};

endmodule

`default_nettype wire

// File: rtl/smsc_ctrl.sv
// ---------------------------------------------------------------------------
// Sliding mode speed controller sequencer
// Steps the datapath through one sample and owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module smsc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire smsc_pkg::smsc_status_t status,
    output smsc_pkg::smsc_cmd_t         cmd
);

    smsc_pkg::smsc_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smsc_pkg::ST_IDLE:     if (s_tvalid) state_next = smsc_pkg::ST_MUL_CE;
            smsc_pkg::ST_MUL_CE:   state_next = smsc_pkg::ST_SURF;
            smsc_pkg::ST_SURF:     state_next = smsc_pkg::ST_ACC_CD;
            smsc_pkg::ST_ACC_CD:   state_next = smsc_pkg::ST_ACC_KS;
            smsc_pkg::ST_ACC_KS:   state_next = smsc_pkg::ST_ACC_SW;
            smsc_pkg::ST_ACC_SW:   state_next = smsc_pkg::ST_DIV_INIT;
            smsc_pkg::ST_DIV_INIT: state_next = smsc_pkg::ST_DIV;
            smsc_pkg::ST_DIV:      if (status.div_done) state_next = smsc_pkg::ST_OUT;
            smsc_pkg::ST_OUT:      if (out_free) state_next = smsc_pkg::ST_IDLE;
            default:               state_next = smsc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            smsc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            smsc_pkg::ST_MUL_CE: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = smsc_pkg::MUL_C_ERR;
            end
            smsc_pkg::ST_SURF: begin
                cmd.surf_en = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = smsc_pkg::MUL_C_DERR;
            end
            smsc_pkg::ST_ACC_CD: begin
                cmd.acc_prod = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = smsc_pkg::MUL_K_S;
            end
            smsc_pkg::ST_ACC_KS:   cmd.acc_prod  = 1'b1;
            smsc_pkg::ST_ACC_SW:   cmd.acc_sw    = 1'b1;
            smsc_pkg::ST_DIV_INIT: cmd.div_start = 1'b1;
            smsc_pkg::ST_DIV:      cmd.div_step  = 1'b1;
            smsc_pkg::ST_OUT:      cmd.out_load  = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smsc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire
